// File: rtl/cfa_pkg.sv
`timescale 1ns / 1ps

package cfa_pkg;

	localparam int MEM_UNITS_DEF     = 256;
	localparam int LIFETIME_BITS_DEF = 16;

	localparam int KIND_W     = 2;
	localparam int SIZE_W     = 9;
	localparam int LIFE_W     = 16;
	localparam int STAT_W     = 2;
	localparam int PROBE_W    = 9;
	localparam int FRAG_W     = 8;
	localparam int STRAT_W    = 2;
	localparam int THR_W      = 9;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
	localparam logic [KIND_W-1:0] KIND_TICK  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

	localparam logic [STAT_W-1:0] STAT_PLACED   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_NOFIT    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NOTALLOC = 2'd2;

	localparam logic [STRAT_W-1:0] STRAT_BEST  = 2'd0;
	localparam logic [STRAT_W-1:0] STRAT_FIRST = 2'd1;
	localparam logic [STRAT_W-1:0] STRAT_NEXT  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_STRATEGY  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;

	localparam logic [STRAT_W-1:0] STRAT_RESET = STRAT_BEST;
	localparam logic [THR_W-1:0]   THR_RESET   = 9'd4;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN,
		ST_FILL,
		ST_TICK,
		ST_CLR,
		ST_DONE
	} state_t;

endpackage

// File: rtl/contiguous_fit_allocator.sv
`timescale 1ns / 1ps

// Contiguous fit allocator over a store of MEM_UNITS lifetime words held in one
// single-port-write, registered-read memory. Every item is handled by a small
// sequencer that walks the store one unit per cycle through one run tracker
// (compare with the previous unit, count the run length). An allocation scans
// the store, then, if a fit was found, writes the placed units one per cycle,
// and then a fragment scan follows; a tick sweeps the store and a clear zeroes
// it before the fragment scan. Items are handled one at a time. After reset the
// store is cleared by a pass over all units during which no item is taken;
// configuration is always taken.
module contiguous_fit_allocator #(
	parameter int MEM_UNITS     = cfa_pkg::MEM_UNITS_DEF,
	parameter int LIFETIME_BITS = cfa_pkg::LIFETIME_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [cfa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [cfa_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [cfa_pkg::KIND_W-1:0]       kind,
	input  logic [cfa_pkg::SIZE_W-1:0]       request_size,
	input  logic [cfa_pkg::LIFE_W-1:0]       lifetime,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [cfa_pkg::STAT_W-1:0]       status,
	output logic [cfa_pkg::PROBE_W-1:0]      run_probes,
	output logic [cfa_pkg::FRAG_W-1:0]       fragment_count
);

	import cfa_pkg::*;

	localparam int AW = $clog2(MEM_UNITS);
	localparam int LW = $clog2(MEM_UNITS + 1);
	localparam int CW = (LW > SIZE_W) ? LW : SIZE_W;
	localparam logic [AW-1:0] LAST = AW'(MEM_UNITS - 1);
	localparam logic [LW-1:0] FULL = LW'(MEM_UNITS);
	localparam logic [FRAG_W-1:0] FRAG_MAX = {FRAG_W{1'b1}};

	logic [LIFETIME_BITS-1:0] mem [MEM_UNITS];

	state_t state_q, state_d;
	logic [STRAT_W-1:0]       strat_q;
	logic [THR_W-1:0]         thr_q;
	logic [AW-1:0]            nfp_q;
	logic [LIFETIME_BITS-1:0] rd_data_q;
	logic [AW-1:0]            addr_q;
	logic                     vld_s1;
	logic [AW-1:0]            idx_s1;
	logic                     run_act_q;
	logic [LIFETIME_BITS-1:0] run_val_q;
	logic [AW-1:0]            run_start_q;
	logic [LW-1:0]            run_len_q;
	logic [LW-1:0]            rem_q;
	logic                     frag_mode_q;
	logic [PROBE_W-1:0]       probe_q;
	logic                     found_q;
	logic [AW-1:0]            pick_pos_q;
	logic [LW-1:0]            best_len_q;
	logic [FRAG_W-1:0]        fragc_q;
	logic [STAT_W-1:0]        status_q;
	logic [SIZE_W-1:0]        size_q;
	logic [LIFETIME_BITS-1:0] life_q;
	logic [SIZE_W-1:0]        fill_left_q;

	logic                     bnd, free, fit_exact, fit_ge, better, place_now;
	logic                     last_run, scan_end, do_place;
	logic [AW-1:0]            place_pos;
	logic [CW-1:0]            len_c, size_c, thr_c;
	logic [CW:0]              end_sum;
	logic [AW-1:0]            nfp_d;
	logic                     start_alloc, start_frag, accept;
	logic                     we;
	logic [AW-1:0]            waddr;
	logic [LIFETIME_BITS-1:0] wdata;
	logic [AW-1:0]            addr_inc;

	assign cfg_ready      = 1'b1;
	assign in_ready       = (state_q == ST_IDLE);
	assign out_valid      = (state_q == ST_DONE);
	assign status         = status_q;
	assign run_probes     = probe_q;
	assign fragment_count = fragc_q;
	assign accept         = in_valid && in_ready;
	assign addr_inc       = (addr_q == LAST) ? '0 : addr_q + 1'b1;

	// run tracker
	always_comb begin
		bnd       = vld_s1 && run_act_q && !(rd_data_q == run_val_q && idx_s1 != '0);
		free      = (run_val_q == '0);
		len_c     = CW'(run_len_q);
		size_c    = CW'(size_q);
		thr_c     = CW'(thr_q);
		fit_exact = free && (len_c == size_c);
		fit_ge    = free && (len_c >= size_c);
		better    = free && (len_c > size_c) && (!found_q || run_len_q < best_len_q);
		place_now = !frag_mode_q && ((strat_q == STRAT_BEST) ? fit_exact : fit_ge);
		last_run  = (run_len_q >= rem_q);
		scan_end  = (state_q == ST_SCAN) && bnd && (place_now || last_run);
		do_place  = place_now || (strat_q == STRAT_BEST && (found_q || better));
		if (place_now) begin
			place_pos = run_start_q;
		end else if (better) begin
			place_pos = run_start_q;
		end else begin
			place_pos = pick_pos_q;
		end
		end_sum = (CW + 1)'(run_start_q) + (CW + 1)'(size_q);
		nfp_d   = (end_sum == (CW + 1)'(MEM_UNITS)) ? '0 : AW'(end_sum);
	end

	always_comb begin
		state_d     = state_q;
		start_alloc = 1'b0;
		start_frag  = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				if (addr_q == LAST) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (kind)
						KIND_ALLOC: begin
							state_d = ST_SCAN;
							if (strat_q == STRAT_BEST || strat_q == STRAT_FIRST ||
							    strat_q == STRAT_NEXT) begin
								start_alloc = 1'b1;
							end else begin
								start_frag = 1'b1;
							end
						end
						KIND_TICK:  state_d = ST_TICK;
						KIND_CLEAR: state_d = ST_CLR;
						default: begin
							state_d    = ST_SCAN;
							start_frag = 1'b1;
						end
					endcase
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					if (frag_mode_q) begin
						state_d = ST_DONE;
					end else if (do_place) begin
						state_d = ST_FILL;
					end else begin
						start_frag = 1'b1;
					end
				end
			end
			ST_FILL: begin
				if (fill_left_q <= SIZE_W'(1) || addr_q == LAST) begin
					state_d    = ST_SCAN;
					start_frag = 1'b1;
				end
			end
			ST_TICK: begin
				if (vld_s1 && idx_s1 == LAST) begin
					state_d    = ST_SCAN;
					start_frag = 1'b1;
				end
			end
			ST_CLR: begin
				if (addr_q == LAST) begin
					state_d    = ST_SCAN;
					start_frag = 1'b1;
				end
			end
			ST_DONE: begin
				if (out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = '0;
		case (state_q)
			ST_INIT, ST_CLR: we = 1'b1;
			ST_TICK: begin
				we    = vld_s1;
				waddr = idx_s1;
				wdata = (rd_data_q == '0) ? '0 : rd_data_q - 1'b1;
			end
			ST_FILL: begin
				we    = (fill_left_q != '0);
				wdata = life_q;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rd_data_q <= mem[addr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strat_q     <= STRAT_RESET;
			thr_q       <= THR_RESET;
			nfp_q       <= '0;
			addr_q      <= '0;
			vld_s1      <= 1'b0;
			run_act_q   <= 1'b0;
			frag_mode_q <= 1'b0;
			found_q     <= 1'b0;
			probe_q     <= '0;
			fragc_q     <= '0;
			status_q    <= STAT_NOTALLOC;
			fill_left_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_STRATEGY) strat_q <= cfg_data[STRAT_W-1:0];
				if (cfg_index == REG_THRESHOLD) thr_q <= cfg_data[THR_W-1:0];
			end

			idx_s1 <= addr_q;
			vld_s1 <= (state_q == ST_SCAN && state_d == ST_SCAN && !start_frag) ||
			          (state_q == ST_TICK && state_d == ST_TICK);

			if (state_q == ST_IDLE) begin
				addr_q <= '0;
			end else begin
				addr_q <= addr_inc;
			end

			if (state_q == ST_FILL && fill_left_q != '0) begin
				fill_left_q <= fill_left_q - 1'b1;
			end

			if (accept) begin
				size_q   <= request_size;
				life_q   <= LIFETIME_BITS'(lifetime);
				probe_q  <= '0;
				status_q <= (kind == KIND_ALLOC) ? STAT_NOFIT : STAT_NOTALLOC;
			end

			if (state_q == ST_SCAN && vld_s1) begin
				if (!run_act_q) begin
					run_act_q   <= 1'b1;
					run_start_q <= idx_s1;
					run_val_q   <= rd_data_q;
					run_len_q   <= LW'(1);
				end else if (!bnd) begin
					run_len_q <= run_len_q + 1'b1;
				end else begin
					rem_q       <= rem_q - run_len_q;
					run_start_q <= idx_s1;
					run_val_q   <= rd_data_q;
					run_len_q   <= LW'(1);
					if (frag_mode_q) begin
						if (free && len_c < thr_c && fragc_q != FRAG_MAX) begin
							fragc_q <= fragc_q + 1'b1;
						end
					end else begin
						if (free) probe_q <= probe_q + 1'b1;
						if (better) begin
							found_q    <= 1'b1;
							pick_pos_q <= run_start_q;
							best_len_q <= run_len_q;
						end
					end
				end
			end

			if (scan_end && !frag_mode_q) begin
				status_q <= do_place ? STAT_PLACED : STAT_NOFIT;
				if (do_place) begin
					addr_q      <= place_pos;
					fill_left_q <= size_q;
				end
				if (place_now && strat_q == STRAT_NEXT) nfp_q <= nfp_d;
			end

			if (start_alloc || start_frag) begin
				addr_q      <= (start_alloc && strat_q == STRAT_NEXT) ? nfp_q : '0;
				rem_q       <= FULL;
				run_act_q   <= 1'b0;
				found_q     <= 1'b0;
				fragc_q     <= '0;
				frag_mode_q <= start_frag;
			end
		end
	end

endmodule
